// ----- design/uph_pkg.sv -----
// Shared types, constants and helpers for the URL path string hash block.
// No dependencies; imported by every module of the block.
package uph_pkg;

    localparam int unsigned ROT_AMT = 19;
    localparam int unsigned HASH_W  = 32;

    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Configuration register indexes
    localparam logic CFG_END_ON_QUERY     = 1'b0;
    localparam logic CFG_SKIP_LAST_IF_DOT = 1'b1;

    typedef struct packed {
        logic [7:0]        ch;
        logic              has_char;
        logic [HASH_W-1:0] seed;
        logic              last;
    } uph_item_t;

    typedef struct packed {
        logic end_on_query;
        logic skip_last_if_dot;
    } uph_cfg_t;

    typedef struct packed {
        logic [HASH_W-1:0] result;
        logic              mid_string;
    } uph_stat_t;

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v);
        rotl = {v[HASH_W-ROT_AMT-1:0], v[HASH_W-1:HASH_W-ROT_AMT]};
    endfunction

endpackage

// ----- design/url_path_string_hash.sv -----
// URL path string hash: rotate-add hash over a byte stream, one byte per request.
// The rotate-add update closes in the core stage; a finished hash is loaded into the result register.
// Throughput: one request per cycle, unless a string end waits on a full, stalled result register.
// Reset: synchronous active-low aresetn clears all valid flags, the string state
// and both configuration registers. Depends on uph_pkg, uph_in_reg, uph_core, uph_out_reg.
module url_path_string_hash (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic        cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] ch, [39:8] seed
    input  logic        s_tuser,   // [0] has_char
    input  logic        s_tlast,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import uph_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers; written only while the block is idle (the user's duty, the block does not enforce it).
    // ---------------------------------------------------------------
    uph_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_END_ON_QUERY:     cfg_next.end_on_query     = cfg_wdata;
                CFG_SKIP_LAST_IF_DOT: cfg_next.skip_last_if_dot = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Input stage
    // ---------------------------------------------------------------
    uph_item_t s_item;
    uph_item_t item;
    logic      item_valid;
    logic      advance;

    assign s_item.ch       = s_tdata[7:0];
    assign s_item.has_char = s_tuser;
    assign s_item.seed     = s_tdata[39:8];
    assign s_item.last     = s_tlast;

    uph_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_item    (s_item),
        .in_ready   (s_tready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // A request that ends a string needs room in the result register;
    // any other request moves into the core unconditionally.
    assign advance = item_valid && (!item.last || !m_tvalid || m_tready);

    // ---------------------------------------------------------------
    // Hash core
    // ---------------------------------------------------------------
    uph_stat_t stat;

    uph_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .stat    (stat)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    uph_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item.last),
        .hash_in  (stat.result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // finishing a string always presents a result next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.last |=> m_tvalid)
        else $error("string end did not produce a result");

    // a pending string end must not overwrite a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && item.last && m_tvalid && !m_tready |-> !advance)
        else $error("result overwritten while stalled");

    // a request that does not end the string leaves the core mid-string
    a_mid_string: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.last |=> stat.mid_string)
        else $error("string state lost after a non-final request");

    // after an ending request the core waits for a new seed
    a_string_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.last |=> !stat.mid_string)
        else $error("string not closed after its last request");

endmodule

// ----- design/uph_in_reg.sv -----
// Input register stage: holds one request until the hash core takes it.
// Depends on uph_pkg.
module uph_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  uph_pkg::uph_item_t in_item,
    output logic               in_ready,
    input  logic               advance,
    output logic               item_valid,
    output uph_pkg::uph_item_t item
);
    import uph_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    uph_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/uph_core.sv -----
// Hash core: per-string state and the rotate-add update.
// Depends on uph_pkg.
module uph_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  uph_pkg::uph_item_t item,
    input  uph_pkg::uph_cfg_t  cfg,
    output uph_pkg::uph_stat_t stat
);
    import uph_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] ckpt_reg, ckpt_next;
    logic              query_reg, query_next;
    logic              slash_reg, slash_next;
    logic              dot_reg, dot_next;
    logic              mid_reg, mid_next;

    logic [HASH_W-1:0] hash_b, ckpt_b;
    logic              query_b, slash_b, dot_b;
    logic              take_char;

    always_comb begin
        // a fresh string starts from the seed with clean flags
        hash_b  = mid_reg ? hash_reg : item.seed;
        ckpt_b  = mid_reg ? ckpt_reg : '0;
        query_b = mid_reg && query_reg;
        slash_b = mid_reg && slash_reg;
        dot_b   = mid_reg && dot_reg;

        hash_next  = hash_b;
        ckpt_next  = ckpt_b;
        query_next = query_b;
        slash_next = slash_b;
        dot_next   = dot_b;

        take_char = item.has_char && !(cfg.end_on_query && query_b);
        if (take_char) begin
            if (cfg.end_on_query && item.ch == CH_QUERY) begin
                query_next = 1'b1;
            end else begin
                if (item.ch == CH_SLASH) begin
                    ckpt_next  = hash_b;
                    slash_next = 1'b1;
                    dot_next   = 1'b0;
                end else if (item.ch == CH_DOT && slash_b) begin
                    dot_next = 1'b1;
                end
                hash_next = hash_b + rotl(hash_b)
                          + {{(HASH_W-8){item.ch[7]}}, item.ch};
            end
        end

        mid_next = !item.last;

        if (!(cfg.end_on_query && query_next) && cfg.skip_last_if_dot
                && slash_next && dot_next) begin
            stat.result = ckpt_next;
        end else begin
            stat.result = hash_next;
        end
        stat.mid_string = mid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg   <= 1'b0;
            query_reg <= 1'b0;
            slash_reg <= 1'b0;
            dot_reg   <= 1'b0;
        end else if (en) begin
            mid_reg   <= mid_next;
            query_reg <= query_next;
            slash_reg <= slash_next;
            dot_reg   <= dot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            ckpt_reg <= '0;
        end else if (en) begin
            hash_reg <= hash_next;
            ckpt_reg <= ckpt_next;
        end
    end

endmodule

// ----- design/uph_out_reg.sv -----
// Result register: holds one finished hash until the downstream side takes it.
// Depends on uph_pkg.
module uph_out_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [uph_pkg::HASH_W-1:0] hash_in,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [uph_pkg::HASH_W-1:0] m_tdata
);
    import uph_pkg::*;

    logic              valid_reg, valid_next;
    logic [HASH_W-1:0] data_reg;

    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= hash_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- tb/uph_hash_checker.sv -----
// Checker for url_path_string_hash: follows the request, result and config ports,
// predicts each string's hash and compares it with the result channel.
// Depends on uph_pkg for widths, rotate amount, character codes and register indexes.
module uph_hash_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic              cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,   // [7:0] ch, [39:8] seed
    input  logic              s_tuser,   // [0] has_char
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,   // [31:0] hash_value
    output int unsigned       mismatches,
    output int unsigned       outstanding
);
    import uph_pkg::*;

    // mode bits as last written
    logic              stop_at_query;
    logic              trim_dotted;

    // string state
    logic [HASH_W-1:0] cur_hash;
    logic [HASH_W-1:0] cut_hash;
    logic              q_hit;
    logic              slash_hit;
    logic              dot_hit;
    logic              in_string;

    logic [HASH_W-1:0]   hash_due[$];
    logic [HASH_W-1:0]   want;
    logic [2*HASH_W-1:0] twin;
    logic [7:0]          rq_ch;
    int unsigned         fail_cnt = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            stop_at_query = 1'b0;
            trim_dotted   = 1'b0;
            cur_hash      = '0;
            cut_hash      = '0;
            q_hit         = 1'b0;
            slash_hit     = 1'b0;
            dot_hit       = 1'b0;
            in_string     = 1'b0;
            hash_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_END_ON_QUERY)
                    stop_at_query = cfg_wdata;
                else if (cfg_addr == CFG_SKIP_LAST_IF_DOT)
                    trim_dotted = cfg_wdata;
            end

            if (s_tvalid && s_tready) begin
                rq_ch = s_tdata[7:0];
                // first request of a string takes the seed
                if (!in_string) begin
                    cur_hash  = s_tdata[39:8];
                    cut_hash  = '0;
                    q_hit     = 1'b0;
                    slash_hit = 1'b0;
                    dot_hit   = 1'b0;
                    in_string = 1'b1;
                end
                if (s_tuser && !(stop_at_query && q_hit)) begin
                    if (stop_at_query && rq_ch == CH_QUERY) begin
                        q_hit = 1'b1;
                    end else begin
                        if (rq_ch == CH_SLASH) begin
                            cut_hash  = cur_hash;
                            slash_hit = 1'b1;
                            dot_hit   = 1'b0;
                        end else if (rq_ch == CH_DOT && slash_hit) begin
                            dot_hit = 1'b1;
                        end
                        twin     = {cur_hash, cur_hash} << ROT_AMT;
                        cur_hash = cur_hash + twin[2*HASH_W-1:HASH_W]
                                 + {{(HASH_W-8){rq_ch[7]}}, rq_ch};
                    end
                end
                if (s_tlast) begin
                    if (!(stop_at_query && q_hit) && trim_dotted && slash_hit && dot_hit)
                        hash_due.push_back(cut_hash);
                    else
                        hash_due.push_back(cur_hash);
                    in_string = 1'b0;
                end
            end

            if (m_tvalid && m_tready) begin
                if (hash_due.size() == 0) begin
                    $error("hash_value: expected none, actual %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = hash_due.pop_front();
                    if (m_tdata !== want) begin
                        $error("hash_value: expected %h, actual %h", want, m_tdata);
                        fail_cnt++;
                    end
                end
            end
        end
        mismatches  <= fail_cnt;
        outstanding <= hash_due.size();
    end

endmodule

// ----- tb/tb_url_path_string_hash.sv -----
// Testbench top for url_path_string_hash: clock, reset, request and config stimulus,
// random back-pressure, and the verdict. Depends on uph_pkg, the block and uph_hash_checker.
module tb_url_path_string_hash;
    import uph_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 182;     // 8 phases, about 1450 random requests
    localparam int unsigned SETTLE      = 4;       // settle margin before mode writes and the verdict

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [7:0] ch, [39:8] seed
    logic        s_tuser;   // [0] has_char
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] hash_value

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;   // sender: chance per cycle of holding back a request
    int unsigned stall_pct;      // receiver: chance per cycle of dropping m_tready
    int unsigned str_left = 0;   // requests left in the random string being sent

    url_path_string_hash uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    uph_hash_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs or drops a result
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[url_path_string_hash] ERROR");
            $finish;
        end
    end

    // receiver back-pressure; stall_pct is set per phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // One request: random idle cycles first, then hold tvalid until accepted.
    // s_tready is read right after the edge, i.e. the value that edge used.
    task automatic send_item(input logic [7:0] ch, input logic has_char,
                             input logic [31:0] seed, input logic last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seed, ch};
        s_tuser  <= has_char;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_text(input string txt, input logic [31:0] seed);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b1, seed, i == txt.len() - 1);
    endtask

    // Drain every pending result, let the pipeline settle, then write both mode bits.
    // The first wait cycle lets the outstanding count catch up with the last request.
    task automatic set_mode(input logic eoq, input logic skip);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_END_ON_QUERY;
        cfg_wdata <= eoq;
        @(posedge aclk);
        cfg_addr  <= CFG_SKIP_LAST_IF_DOT;
        cfg_wdata <= skip;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stim
        int unsigned r;
        logic [7:0]  ch;
        logic        has;
        logic [31:0] seed;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_END_ON_QUERY;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        stall_pct <= 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part, reset modes first ---
        send_item(8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1);   // empty string: result is the seed
        send_item(8'h00, 1'b1, 32'h0000_0000, 1'b1);   // NUL byte still hashed
        send_item(8'hFF, 1'b1, 32'h8000_0000, 1'b1);   // negative byte, sign extension

        set_mode(1'b1, 1'b1);
        send_text("/x/y.z?q", 32'h1234_5678);          // query wins over trimming
        send_text("/a/b.c", 32'hFFFF_FFFF);            // dotted last component dropped
        // request without a byte mid-string; later seeds are ignored
        send_item("a", 1'b1, 32'h0F0F_0F0F, 1'b0);
        send_item(8'h80, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_item("b", 1'b1, 32'h0000_0000, 1'b1);

        // --- random part: URL-like strings, all four mode settings, four idle mixes.
        // A string may straddle a phase, so modes also change mid-string. ---
        for (int p = 0; p < 8; p++) begin
            set_mode(p[0], p[1]);
            case (p / 2)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 65; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 65; end
                default: begin idle_pct = 13; stall_pct <= 13; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (str_left == 0)
                    str_left = ($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                                        : $urandom_range(40, 13);
                r = $urandom_range(99);
                if (r < 15)      ch = CH_SLASH;
                else if (r < 27) ch = CH_DOT;
                else if (r < 35) ch = CH_QUERY;
                else if (r < 75) ch = 8'h61 + 8'($urandom_range(25));
                else             ch = 8'($urandom_range(255));
                has = ($urandom_range(19) != 0);
                r = $urandom_range(15);
                if (r == 0)      seed = 32'h0000_0000;
                else if (r == 1) seed = 32'hFFFF_FFFF;
                else             seed = $urandom();
                send_item(ch, has, seed, str_left == 1);
                str_left--;
            end
        end

        // --- wind down ---
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2 * SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("[url_path_string_hash] OK");
        else
            $display("[url_path_string_hash] ERROR");
        $finish;
    end

endmodule
